// ===== rtl/core/gbfd_pkg.sv =====
`timescale 1ns / 1ps

package gbfd_pkg;

  localparam int unsigned CrcBytes  = 4;
  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam int unsigned PosWidth  = 17;
  localparam int unsigned LenWidth  = 16;
  localparam int unsigned AddrWidth = 5;

  typedef enum logic [2:0] {
    RegFirstSync   = 3'd0,
    RegSecondSync  = 3'd1,
    RegLongMarker  = 3'd2,
    RegShortMarker = 3'd3,
    RegLongHdrLen  = 3'd4,
    RegShortHdrLen = 3'd5,
    RegLongLenOff  = 3'd6,
    RegShortLenOff = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    PhHunt0 = 4'b0001,
    PhHunt1 = 4'b0010,
    PhHunt2 = 4'b0100,
    PhFrame = 4'b1000
  } phase_e;

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] w;
    w = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      w = w[0] ? ((w >> 1) ^ CrcPoly) : (w >> 1);
    end
    return {8'd0, crc[31:8]} ^ w;
  endfunction

endpackage

// ===== rtl/core/gnss_binary_frame_deframer_crc32.sv =====
`timescale 1ns / 1ps

// Byte-stream deframer with reflected CRC-32 check.
// Input channel: one received byte per transfer (in_valid_i / in_ready_o, byte_in_i).
// The two sync bytes produce no output; the marker byte and every byte after it
// produce one output transfer carrying the byte, its frame position, header and
// long-header flags, the last-byte flag, the CRC match flag and the captured
// payload length.
// A result is registered and appears on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled; the CRC byte update and counters
// sit in one combinational stage between the input port and the output register.
// Configuration: eight 8-bit registers on an APB-style port at byte addresses
// 4*i; pready is always high and reads return the register value.
// Reset: all configuration registers take their default values, the hunt
// restarts at the first sync byte and the output register is empty.
// Stall: while the output register holds a result that is not taken, in_ready_o
// is low and no byte is accepted; when the result is taken in the same cycle a
// new byte is accepted.
module gnss_binary_frame_deframer_crc32 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     byte_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     data_byte_o,
  output logic [gbfd_pkg::PosWidth-1:0]  position_o,
  output logic                           in_header_o,
  output logic                           long_header_o,
  output logic                           last_in_frame_o,
  output logic                           crc_ok_o,
  output logic [gbfd_pkg::LenWidth-1:0]  payload_length_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gbfd_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import gbfd_pkg::*;

  logic [7:0] first_sync_q, second_sync_q, long_marker_q, short_marker_q;
  logic [7:0] long_hdr_q, short_hdr_q, long_off_q, short_off_q;

  phase_e                phase_q, phase_d;
  logic [PosWidth-1:0]   cnt_q, cnt_d;
  logic                  is_long_q, is_long_d;
  logic [LenWidth-1:0]   len_q, len_d;
  logic [31:0]           crc_q, crc_d;
  logic [31:0]           rx_q, rx_d;

  logic                  out_valid_q;
  logic [7:0]            data_q;
  logic [PosWidth-1:0]   pos_q;
  logic                  hdr_q, long_q, last_q, ok_q;
  logic [LenWidth-1:0]   plen_q;

  logic                  in_fire, cfg_we;
  reg_idx_e              cfg_idx;

  logic                  framed;
  logic [7:0]            hlen;
  logic [PosWidth-1:0]   pos;
  logic [LenWidth-1:0]   len_base;
  logic [31:0]           rx_base;
  logic                  hdr_flag, body_flag, last_flag, ok_flag;
  logic [PosWidth-1:0]   body_end;
  logic [8:0]            long_off_hi;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign pready     = 1'b1;
  assign cfg_we     = psel && penable && pwrite;
  assign cfg_idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sync_q   <= 8'd170;
      second_sync_q  <= 8'd68;
      long_marker_q  <= 8'd18;
      short_marker_q <= 8'd19;
      long_hdr_q     <= 8'd28;
      short_hdr_q    <= 8'd12;
      long_off_q     <= 8'd8;
      short_off_q    <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegFirstSync:   first_sync_q   <= pwdata[7:0];
        RegSecondSync:  second_sync_q  <= pwdata[7:0];
        RegLongMarker:  long_marker_q  <= pwdata[7:0];
        RegShortMarker: short_marker_q <= pwdata[7:0];
        RegLongHdrLen:  long_hdr_q     <= pwdata[7:0];
        RegShortHdrLen: short_hdr_q    <= pwdata[7:0];
        RegLongLenOff:  long_off_q     <= pwdata[7:0];
        RegShortLenOff: short_off_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (cfg_idx)
      RegFirstSync:   prdata[7:0] = first_sync_q;
      RegSecondSync:  prdata[7:0] = second_sync_q;
      RegLongMarker:  prdata[7:0] = long_marker_q;
      RegShortMarker: prdata[7:0] = short_marker_q;
      RegLongHdrLen:  prdata[7:0] = long_hdr_q;
      RegShortHdrLen: prdata[7:0] = short_hdr_q;
      RegLongLenOff:  prdata[7:0] = long_off_q;
      RegShortLenOff: prdata[7:0] = short_off_q;
      default: ;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    is_long_d = is_long_q;
    len_d     = len_q;
    crc_d     = crc_q;
    rx_d      = rx_q;
    framed    = 1'b0;
    pos       = cnt_q;
    len_base  = len_q;
    rx_base   = rx_q;
    hdr_flag  = 1'b0;
    body_flag = 1'b0;
    last_flag = 1'b0;
    ok_flag   = 1'b0;
    hlen      = 8'd3;
    body_end  = '0;
    long_off_hi = {1'b0, long_off_q} + 9'd1;

    unique case (phase_q)
      PhHunt0: begin
        if (byte_in_i == first_sync_q) begin
          crc_d   = crc_update(32'd0, byte_in_i);
          phase_d = PhHunt1;
        end else begin
          phase_d = PhHunt0;
        end
      end
      PhHunt1: begin
        if (byte_in_i == second_sync_q) begin
          crc_d   = crc_update(crc_q, byte_in_i);
          phase_d = PhHunt2;
        end else if (byte_in_i == first_sync_q) begin
          crc_d   = crc_update(32'd0, byte_in_i);
          phase_d = PhHunt1;
        end else begin
          phase_d = PhHunt0;
        end
      end
      PhHunt2: begin
        if (byte_in_i == long_marker_q || byte_in_i == short_marker_q) begin
          framed    = 1'b1;
          is_long_d = (byte_in_i == long_marker_q);
          pos       = PosWidth'(2);
          len_base  = '0;
          rx_base   = '0;
        end else if (byte_in_i == first_sync_q) begin
          crc_d   = crc_update(32'd0, byte_in_i);
          phase_d = PhHunt1;
        end else begin
          phase_d = PhHunt0;
        end
      end
      PhFrame: framed = 1'b1;
      default: phase_d = PhHunt0;
    endcase

    if (framed) begin
      hlen = is_long_d ? long_hdr_q : short_hdr_q;
      if (hlen < 8'd3) begin
        hlen = 8'd3;
      end
      hdr_flag = (pos < PosWidth'(hlen));
      len_d    = len_base;
      if (hdr_flag) begin
        if (is_long_d) begin
          if (pos == PosWidth'(long_off_q)) begin
            len_d = {len_base[15:8], byte_in_i};
          end else if (pos == PosWidth'(long_off_hi)) begin
            len_d = {byte_in_i, len_base[7:0]};
          end
        end else if (pos == PosWidth'(short_off_q)) begin
          len_d = {8'd0, byte_in_i};
        end
      end
      body_end  = PosWidth'(hlen) + PosWidth'(len_d);
      body_flag = (pos < body_end);
      rx_d      = rx_base;
      if (body_flag) begin
        crc_d = crc_update(crc_q, byte_in_i);
      end else begin
        rx_d = {byte_in_i, rx_base[31:8]};
      end
      last_flag = (pos == body_end + PosWidth'(CrcBytes - 1));
      if (last_flag) begin
        ok_flag = (crc_d == rx_d);
        phase_d = PhHunt0;
        cnt_d   = '0;
      end else begin
        phase_d = PhFrame;
        cnt_d   = pos + PosWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt0;
      cnt_q       <= '0;
      is_long_q   <= 1'b0;
      len_q       <= '0;
      crc_q       <= '0;
      rx_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q   <= phase_d;
        cnt_q     <= cnt_d;
        is_long_q <= is_long_d;
        len_q     <= len_d;
        crc_q     <= crc_d;
        rx_q      <= rx_d;
      end
      if (in_fire) begin
        out_valid_q <= framed;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && framed) begin
      data_q <= byte_in_i;
      pos_q  <= pos;
      hdr_q  <= hdr_flag;
      long_q <= is_long_d;
      last_q <= last_flag;
      ok_q   <= ok_flag;
      plen_q <= len_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_byte_o      = data_q;
  assign position_o       = pos_q;
  assign in_header_o      = hdr_q;
  assign long_header_o    = long_q;
  assign last_in_frame_o  = last_q;
  assign crc_ok_o         = ok_q;
  assign payload_length_o = plen_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("input stalled with empty output");

  a_pos_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> position_o >= PosWidth'(2)) else $error("framed position below marker");

  a_last_not_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_in_frame_o |-> !in_header_o) else $error("last byte inside header");

  a_ok_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crc_ok_o |-> last_in_frame_o) else $error("crc_ok off the last byte");

  a_hunt_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && framed && last_flag |=> phase_q == PhHunt0 && cnt_q == '0)
    else $error("frame end did not restart hunt");

endmodule

// ===== test/gnss_binary_frame_deframer_crc32_tb.sv =====
`timescale 1ns / 1ps

module gnss_binary_frame_deframer_crc32_tb;
  import gbfd_pkg::*;

  localparam int unsigned SettleCycles = 4;
  localparam int unsigned NumSettings  = 9;

  typedef struct packed {
    logic [7:0]          data;
    logic [PosWidth-1:0] pos;
    logic                in_hdr;
    logic                long_hdr;
    logic                last;
    logic                ok;
    logic [LenWidth-1:0] plen;
  } frame_record_t;

  class deframe_scoreboard;
    logic [7:0]          regs [8];
    phase_e              st;
    logic [PosWidth-1:0] next_pos;
    logic                long_frame;
    logic [LenWidth-1:0] plen;
    logic [31:0]         crc_acc;
    logic [31:0]         crc_rx;
    frame_record_t       pending [$];
    int unsigned         n_in = 0;
    int unsigned         n_out = 0;
    int unsigned         n_frames = 0;
    int unsigned         n_good = 0;
    int unsigned         n_err = 0;

    function new();
      regs = '{8'hAA, 8'h44, 8'h12, 8'h13, 8'd28, 8'd12, 8'd8, 8'd3};
      st = PhHunt0;
      next_pos = '0;
      long_frame = 1'b0;
      plen = '0;
      crc_acc = '0;
      crc_rx = '0;
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
      return x;
    endfunction

    function void set_reg(reg_idx_e idx, logic [7:0] v);
      regs[idx] = v;
    endfunction

    function void first_sync(logic [7:0] b);
      if (b == regs[RegFirstSync]) begin
        crc_acc = crc_step(32'h0, b);
        st = PhHunt1;
      end else begin
        st = PhHunt0;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned   hlen;
      int unsigned   pos;
      int unsigned   off;
      frame_record_t r;
      n_in++;
      case (st)
        PhHunt0: begin
          first_sync(b);
          return;
        end
        PhHunt1: begin
          if (b == regs[RegSecondSync]) begin
            crc_acc = crc_step(crc_acc, b);
            st = PhHunt2;
          end else begin
            first_sync(b);
          end
          return;
        end
        PhHunt2: begin
          if (b == regs[RegLongMarker]) begin
            long_frame = 1'b1;
          end else if (b == regs[RegShortMarker]) begin
            long_frame = 1'b0;
          end else begin
            first_sync(b);
            return;
          end
          plen = '0;
          crc_rx = '0;
          next_pos = PosWidth'(2);
          st = PhFrame;
        end
        default: st = PhFrame;
      endcase
      hlen = long_frame ? regs[RegLongHdrLen] : regs[RegShortHdrLen];
      if (hlen < 3) hlen = 3;
      pos = next_pos;
      if (pos < hlen) begin
        if (long_frame) begin
          off = regs[RegLongLenOff];
          if (pos == off) plen[7:0] = b;
          else if (pos == off + 1) plen[15:8] = b;
        end else if (pos == regs[RegShortLenOff]) begin
          plen = {8'h00, b};
        end
      end
      if (pos < hlen + plen) crc_acc = crc_step(crc_acc, b);
      else crc_rx = {b, crc_rx[31:8]};
      r.data = b;
      r.pos = pos[PosWidth-1:0];
      r.in_hdr = (pos < hlen);
      r.long_hdr = long_frame;
      r.last = (pos == hlen + plen + CrcBytes - 1);
      r.ok = r.last && (crc_acc == crc_rx);
      r.plen = plen;
      if (r.last) begin
        st = PhHunt0;
        next_pos = '0;
      end else begin
        next_pos = PosWidth'(pos + 1);
      end
      pending = {pending, r};
    endfunction

    function string show(frame_record_t r);
      return $sformatf("byte %02h pos %0d hdr %0b long %0b last %0b crc_ok %0b len %0d",
                       r.data, r.pos, r.in_hdr, r.long_hdr, r.last, r.ok, r.plen);
    endfunction

    function void flag(string msg);
      n_err++;
      if (n_err <= 10) $display("%s", msg);
    endfunction

    function void check_result(frame_record_t got);
      frame_record_t want;
      n_out++;
      if (got.last) begin
        n_frames++;
        if (got.ok) n_good++;
      end
      if (pending.size() == 0) begin
        flag({"record with nothing expected: ", show(got)});
        return;
      end
      want = pending.pop_front();
      if (got.data !== want.data || got.pos !== want.pos || got.in_hdr !== want.in_hdr ||
          got.long_hdr !== want.long_hdr || got.last !== want.last || got.ok !== want.ok ||
          got.plen !== want.plen) begin
        flag({"expected ", show(want), "\n     got ", show(got)});
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           byte_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [7:0]           data_byte_o;
  logic [PosWidth-1:0]  position_o;
  logic                 in_header_o;
  logic                 long_header_o;
  logic                 last_in_frame_o;
  logic                 crc_ok_o;
  logic [LenWidth-1:0]  payload_length_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  deframe_scoreboard sb;
  frame_record_t     seen;
  logic [7:0]        frame_q [$];
  int unsigned       src_idle_pct;
  int unsigned       snk_stall_pct;

  gnss_binary_frame_deframer_crc32 i_dut (.*);

  assign seen = {data_byte_o, position_o, in_header_o, long_header_o, last_in_frame_o,
                 crc_ok_o, payload_length_o};

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= snk_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(seen);
  end

  initial begin
    #4_000_000;
    $display("watchdog expired with %0d records outstanding", sb.pending.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned pick_len(bit long_sel);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(16);
    if (r < 90) return $urandom_range(64, 17);
    if (r < 98 || !long_sel) return $urandom_range(255, 65);
    return $urandom_range(300, 256);
  endfunction

  function automatic void build_frame(bit long_sel, int unsigned want_len, bit corrupt);
    logic [7:0]  mark;
    bit          is_long;
    int unsigned hlen;
    int unsigned off;
    int unsigned eff;
    int unsigned flip;
    logic [31:0] c;
    mark = long_sel ? sb.regs[RegLongMarker] : sb.regs[RegShortMarker];
    is_long = (mark == sb.regs[RegLongMarker]);
    hlen = is_long ? sb.regs[RegLongHdrLen] : sb.regs[RegShortHdrLen];
    if (hlen < 3) hlen = 3;
    off = is_long ? sb.regs[RegLongLenOff] : sb.regs[RegShortLenOff];
    if (!is_long) want_len = want_len & 8'hFF;
    frame_q.delete();
    frame_q = {frame_q, sb.regs[RegFirstSync]};
    frame_q = {frame_q, sb.regs[RegSecondSync]};
    frame_q = {frame_q, mark};
    while (frame_q.size() < hlen) frame_q = {frame_q, 8'($urandom)};
    eff = 0;
    if (off < hlen) begin
      frame_q[off] = want_len[7:0];
      eff = want_len[7:0];
    end
    if (is_long && off + 1 < hlen) begin
      frame_q[off + 1] = want_len[15:8];
      eff += want_len[15:8] << 8;
    end
    repeat (eff) frame_q = {frame_q, 8'($urandom)};
    c = '0;
    foreach (frame_q[i]) c = deframe_scoreboard::crc_step(c, frame_q[i]);
    for (int i = 0; i < 4; i++) frame_q = {frame_q, c[8*i +: 8]};
    if (corrupt) begin
      flip = $urandom_range(frame_q.size() - 1, hlen);
      frame_q[flip] = frame_q[flip] ^ 8'(1 << $urandom_range(7));
    end
  endfunction

  task automatic push_byte(logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) push_byte(frame_q[i]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(int unsigned p);
    logic [7:0] v [8];
    case (p)
      1: v = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'd4, 8'd4, 8'd3, 8'd3};
      2: v = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'd255, 8'd255, 8'd253, 8'd254};
      3: v = '{8'hAA, 8'h44, 8'h12, 8'h12, 8'd28, 8'd12, 8'd8, 8'd3};
      4: v = '{8'h55, 8'h0F, 8'hF0, 8'h3C, 8'd10, 8'd6, 8'd12, 8'd200};
      default: begin
        v[0] = 8'($urandom);
        do v[1] = 8'($urandom); while (v[1] == v[0]);
        do v[2] = 8'($urandom); while (v[2] == v[0] || v[2] == v[1]);
        do v[3] = 8'($urandom); while (v[3] == v[0] || v[3] == v[1] || v[3] == v[2]);
        v[4] = 8'($urandom_range(32, 4));
        v[5] = 8'($urandom_range(32, 4));
        v[6] = 8'($urandom_range(v[4] + 1, 3));
        v[7] = 8'($urandom_range(v[5] + 1, 3));
      end
    endcase
    for (int i = 0; i < 8; i++) reg_write(reg_idx_e'(i), v[i]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_traffic(int unsigned budget);
    int unsigned sent;
    int unsigned roll;
    bit          long_sel;
    logic [7:0]  bad;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        repeat ($urandom_range(5, 1)) push_byte(8'($urandom));
      end else if (roll < 18) begin
        push_byte(sb.regs[RegFirstSync]);
        if ($urandom_range(1)) begin
          push_byte(sb.regs[RegSecondSync]);
          do bad = 8'($urandom);
          while (bad == sb.regs[RegLongMarker] || bad == sb.regs[RegShortMarker]);
          push_byte(bad);
        end
      end else begin
        long_sel = $urandom_range(1);
        build_frame(long_sel, pick_len(long_sel), $urandom_range(99) < 15);
        send_frame();
        sent += frame_q.size();
      end
    end
  endtask

  initial begin
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    byte_in_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned p = 0; p < NumSettings; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 57; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 57; end
        default: begin src_idle_pct = 35; snk_stall_pct = 35; end
      endcase
      if (p > 0) begin
        drain();
        apply_setting(p);
      end else begin
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'hAA);
        push_byte(8'hAA);
        push_byte(8'h44);
        push_byte(8'hAA);
        build_frame(1'b0, 0, 1'b0);
        send_frame();
      end
      random_traffic(p == 2 ? 360 : 140);
    end
    drain();

    if (sb.pending.size() != 0) sb.flag("records still expected at end of run");
    $display("covered %0d bytes in, %0d records out, %0d frames closed (%0d with CRC match)",
             sb.n_in, sb.n_out, sb.n_frames, sb.n_good);
    $display("across %0d register settings incl. extremes and equal markers, four idle mixes",
             NumSettings);
    if (sb.n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", sb.n_err);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
